// ===== hw/rtl/qbt_pkg.sv =====
`default_nettype none

package qbt_pkg;

  localparam int COORD_W    = 32;
  localparam int COLOR_W    = 32;
  localparam int COUNT_W    = 6;
  localparam int MAX_POINTS = 32;
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);

  localparam int FRAC_W     = 16;
  localparam int T_W        = FRAC_W + 1;
  localparam int W_W        = 2 * FRAC_W + 1;
  localparam int PROD_W     = COORD_W + 2 * FRAC_W;
  localparam int SUM_W      = PROD_W + 2;
  localparam int SHIFT_W    = 2 * FRAC_W;
  localparam int STEP_IDX_W = 6;

  localparam int NUM_AXES = 3;
  localparam int NUM_CTRL = 3;

  localparam int AXIS_X = 0;
  localparam int AXIS_Y = 1;
  localparam int AXIS_Z = 2;

  localparam int CTRL_START = 0;
  localparam int CTRL_MID   = 1;
  localparam int CTRL_END   = 2;

  localparam logic [T_W-1:0]   ONE_Q16    = T_W'(1) << FRAC_W;
  localparam logic [SUM_W-1:0] ROUND_BIAS = SUM_W'(1) << (SHIFT_W - 1);

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [COLOR_W-1:0]        color_t;
  typedef logic [T_W-1:0]            tparam_t;
  typedef logic [W_W-1:0]            weight_t;
  typedef logic signed [PROD_W-1:0]  prod_t;
  typedef logic signed [SUM_W-1:0]   sum_t;

  // ceil(1.0 / m) in Q1.16, m = point count minus one
  function automatic tparam_t step_lut(input logic [STEP_IDX_W-1:0] m);
    tparam_t s;
    case (m)
      6'd1:  s = 17'd65536;
      6'd2:  s = 17'd32768;
      6'd3:  s = 17'd21846;
      6'd4:  s = 17'd16384;
      6'd5:  s = 17'd13108;
      6'd6:  s = 17'd10923;
      6'd7:  s = 17'd9363;
      6'd8:  s = 17'd8192;
      6'd9:  s = 17'd7282;
      6'd10: s = 17'd6554;
      6'd11: s = 17'd5958;
      6'd12: s = 17'd5462;
      6'd13: s = 17'd5042;
      6'd14: s = 17'd4682;
      6'd15: s = 17'd4370;
      6'd16: s = 17'd4096;
      6'd17: s = 17'd3856;
      6'd18: s = 17'd3641;
      6'd19: s = 17'd3450;
      6'd20: s = 17'd3277;
      6'd21: s = 17'd3121;
      6'd22: s = 17'd2979;
      6'd23: s = 17'd2850;
      6'd24: s = 17'd2731;
      6'd25: s = 17'd2622;
      6'd26: s = 17'd2521;
      6'd27: s = 17'd2428;
      6'd28: s = 17'd2341;
      6'd29: s = 17'd2260;
      6'd30: s = 17'd2185;
      6'd31: s = 17'd2115;
      6'd32: s = 17'd2048;
      6'd33: s = 17'd1986;
      6'd34: s = 17'd1928;
      6'd35: s = 17'd1873;
      6'd36: s = 17'd1821;
      6'd37: s = 17'd1772;
      6'd38: s = 17'd1725;
      6'd39: s = 17'd1681;
      6'd40: s = 17'd1639;
      6'd41: s = 17'd1599;
      6'd42: s = 17'd1561;
      6'd43: s = 17'd1525;
      6'd44: s = 17'd1490;
      6'd45: s = 17'd1457;
      6'd46: s = 17'd1425;
      6'd47: s = 17'd1395;
      6'd48: s = 17'd1366;
      6'd49: s = 17'd1338;
      6'd50: s = 17'd1311;
      6'd51: s = 17'd1286;
      6'd52: s = 17'd1261;
      6'd53: s = 17'd1237;
      6'd54: s = 17'd1214;
      6'd55: s = 17'd1192;
      6'd56: s = 17'd1171;
      6'd57: s = 17'd1150;
      6'd58: s = 17'd1130;
      6'd59: s = 17'd1111;
      6'd60: s = 17'd1093;
      6'd61: s = 17'd1075;
      6'd62: s = 17'd1058;
      6'd63: s = 17'd1041;
      default: s = '0;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/quadratic_bezier_tessellator_core.sv =====
`default_nettype none

// quadratic bezier tessellator
// input channel (in_valid/in_ready): one curve word with start, mid and end control
// points (signed Q16.16), a color and a point count n; counts above MAX_POINTS clamp
// output channel (out_valid/out_ready): n point words along the curve, each with the
// curve color, out_last_point set on the final one; a count of zero gives no output
// a sequencer steps t from 0 by ceil(1/(n-1)), saturating at 1.0, and issues one
// point per cycle into a five stage pipeline (issue, weights, products, sum, output)
// issue pauses while the output stalls, and the curve word is registered first
// throughput: one point per cycle unless the output stalls; a curve of n points
// holds in_ready low until its last point has issued, then in_ready rises again
// the next curve word is taken while earlier points still drain through the pipe
// when the receiver stalls, the whole pipe holds in place and nothing is lost
// reset (rst_n low, synchronous) empties the pipe and the sequencer; in_ready is
// high in the first cycle after reset

module quadratic_bezier_tessellator_core
  import qbt_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,

  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [COORD_W-1:0] in_start_x,
  input  wire logic [COORD_W-1:0] in_start_y,
  input  wire logic [COORD_W-1:0] in_start_z,
  input  wire logic [COORD_W-1:0] in_mid_x,
  input  wire logic [COORD_W-1:0] in_mid_y,
  input  wire logic [COORD_W-1:0] in_mid_z,
  input  wire logic [COORD_W-1:0] in_end_x,
  input  wire logic [COORD_W-1:0] in_end_y,
  input  wire logic [COORD_W-1:0] in_end_z,
  input  wire logic [COLOR_W-1:0] in_curve_color,
  input  wire logic [COUNT_W-1:0] in_point_count,

  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [COORD_W-1:0]      out_point_x,
  output logic [COORD_W-1:0]      out_point_y,
  output logic [COORD_W-1:0]      out_point_z,
  output logic [COLOR_W-1:0]      out_point_color,
  output logic                    out_last_point
);

  // sequencer
  coord_t           held_r [NUM_CTRL][NUM_AXES];
  color_t           color_r;
  tparam_t          t_r;
  tparam_t          step_r;
  logic [CNT_W-1:0] left_r;

  coord_t           in_pts [NUM_CTRL][NUM_AXES];
  logic [CNT_W-1:0] n_sat;
  logic [CNT_W-1:0] m_cnt;
  logic [T_W:0]     t_sum;
  tparam_t          t_nxt;
  logic             accept;
  logic             adv;
  logic             issue;

  // pipeline stages
  logic    s1_valid_r, s2_valid_r, s3_valid_r, s4_valid_r, out_valid_r;
  logic    s1_last_r, s2_last_r, s3_last_r, s4_last_r, out_last_r;
  color_t  s1_color_r, s2_color_r, s3_color_r, s4_color_r, out_color_r;
  tparam_t s1_t_r;
  coord_t  s1_pts_r [NUM_CTRL][NUM_AXES];
  coord_t  s2_pts_r [NUM_CTRL][NUM_AXES];
  weight_t s2_w_r [NUM_CTRL];
  prod_t   s3_prod_r [NUM_AXES][NUM_CTRL];
  sum_t    s4_sum_r [NUM_AXES];
  coord_t  out_pt_r [NUM_AXES];

  tparam_t                   s1_u;
  logic [2*T_W-1:0]          s1_uu, s1_ut, s1_tt;
  weight_t                   s2_w_nxt [NUM_CTRL];
  prod_t                     s3_prod_nxt [NUM_AXES][NUM_CTRL];
  sum_t                      s4_sum_nxt [NUM_AXES];
  coord_t                    out_pt_nxt [NUM_AXES];

  assign in_pts[CTRL_START][AXIS_X] = in_start_x;
  assign in_pts[CTRL_START][AXIS_Y] = in_start_y;
  assign in_pts[CTRL_START][AXIS_Z] = in_start_z;
  assign in_pts[CTRL_MID][AXIS_X]   = in_mid_x;
  assign in_pts[CTRL_MID][AXIS_Y]   = in_mid_y;
  assign in_pts[CTRL_MID][AXIS_Z]   = in_mid_z;
  assign in_pts[CTRL_END][AXIS_X]   = in_end_x;
  assign in_pts[CTRL_END][AXIS_Y]   = in_end_y;
  assign in_pts[CTRL_END][AXIS_Z]   = in_end_z;

  assign in_ready = (left_r == '0);
  assign accept   = in_valid && in_ready;
  assign adv      = !out_valid_r || out_ready;
  assign issue    = adv && (left_r != '0);

  always_comb begin
    if (int'(in_point_count) > MAX_POINTS) begin
      n_sat = CNT_W'(MAX_POINTS);
    end else begin
      n_sat = CNT_W'(in_point_count);
    end
    m_cnt = n_sat - CNT_W'(1);
    t_sum = {1'b0, t_r} + {1'b0, step_r};
    // t saturates at one
    if (t_sum > {1'b0, ONE_Q16}) begin
      t_nxt = ONE_Q16;
    end else begin
      t_nxt = t_sum[T_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      held_r  <= in_pts;
      color_r <= in_curve_color;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t_r    <= '0;
      step_r <= '0;
      left_r <= '0;
    end else if (accept) begin
      t_r    <= '0;
      step_r <= (n_sat >= CNT_W'(2)) ? step_lut(STEP_IDX_W'(m_cnt)) : '0;
      left_r <= n_sat;
    end else if (issue) begin
      t_r    <= t_nxt;
      left_r <= left_r - CNT_W'(1);
    end
  end

  // weights: u*u, 2*u*t, t*t sum to 2^32
  always_comb begin
    s1_u  = ONE_Q16 - s1_t_r;
    s1_uu = {{T_W{1'b0}}, s1_u} * {{T_W{1'b0}}, s1_u};
    s1_ut = {{T_W{1'b0}}, s1_u} * {{T_W{1'b0}}, s1_t_r};
    s1_tt = {{T_W{1'b0}}, s1_t_r} * {{T_W{1'b0}}, s1_t_r};
    s2_w_nxt[CTRL_START] = s1_uu[W_W-1:0];
    s2_w_nxt[CTRL_MID]   = {s1_ut[W_W-2:0], 1'b0};
    s2_w_nxt[CTRL_END]   = s1_tt[W_W-1:0];
  end

  // weight of exactly 2^32 only occurs alone, then the product is a plain shift
  always_comb begin
    logic signed [W_W+COORD_W-1:0] mul;
    for (int a = 0; a < NUM_AXES; a++) begin
      for (int c = 0; c < NUM_CTRL; c++) begin
        mul = (W_W+COORD_W)'($signed({1'b0, s2_w_r[c][W_W-2:0]}))
            * (W_W+COORD_W)'(s2_pts_r[c][a]);
        if (s2_w_r[c][W_W-1]) begin
          s3_prod_nxt[a][c] = {s2_pts_r[c][a], {SHIFT_W{1'b0}}};
        end else begin
          s3_prod_nxt[a][c] = mul[PROD_W-1:0];
        end
      end
    end
  end

  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      s4_sum_nxt[a] = {{(SUM_W-PROD_W){s3_prod_r[a][CTRL_START][PROD_W-1]}},
                       s3_prod_r[a][CTRL_START]}
                    + {{(SUM_W-PROD_W){s3_prod_r[a][CTRL_MID][PROD_W-1]}},
                       s3_prod_r[a][CTRL_MID]}
                    + {{(SUM_W-PROD_W){s3_prod_r[a][CTRL_END][PROD_W-1]}},
                       s3_prod_r[a][CTRL_END]}
                    + ROUND_BIAS;
    end
  end

  // floor shift then clamp to signed 32 bits
  always_comb begin
    logic [SUM_W-SHIFT_W-1:0] q;
    for (int a = 0; a < NUM_AXES; a++) begin
      q = s4_sum_r[a][SUM_W-1:SHIFT_W];
      if (q[SUM_W-SHIFT_W-1:COORD_W-1] == '0 || q[SUM_W-SHIFT_W-1:COORD_W-1] == '1) begin
        out_pt_nxt[a] = q[COORD_W-1:0];
      end else if (q[SUM_W-SHIFT_W-1]) begin
        out_pt_nxt[a] = {1'b1, {(COORD_W-1){1'b0}}};
      end else begin
        out_pt_nxt[a] = {1'b0, {(COORD_W-1){1'b1}}};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      s4_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r  <= issue;
      s2_valid_r  <= s1_valid_r;
      s3_valid_r  <= s2_valid_r;
      s4_valid_r  <= s3_valid_r;
      out_valid_r <= s4_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_t_r      <= t_r;
      s1_pts_r    <= held_r;
      s1_color_r  <= color_r;
      s1_last_r   <= (left_r == CNT_W'(1));

      s2_w_r      <= s2_w_nxt;
      s2_pts_r    <= s1_pts_r;
      s2_color_r  <= s1_color_r;
      s2_last_r   <= s1_last_r;

      s3_prod_r   <= s3_prod_nxt;
      s3_color_r  <= s2_color_r;
      s3_last_r   <= s2_last_r;

      s4_sum_r    <= s4_sum_nxt;
      s4_color_r  <= s3_color_r;
      s4_last_r   <= s3_last_r;

      out_pt_r    <= out_pt_nxt;
      out_color_r <= s4_color_r;
      out_last_r  <= s4_last_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_point_x     = out_pt_r[AXIS_X];
  assign out_point_y     = out_pt_r[AXIS_Y];
  assign out_point_z     = out_pt_r[AXIS_Z];
  assign out_point_color = out_color_r;
  assign out_last_point  = out_last_r;

`ifndef SYNTHESIS
  // the final point of a multi-point run lands exactly on the end point
  assert property (@(posedge clk) disable iff (!rst_n)
    issue && left_r == CNT_W'(1) && step_r != '0 |-> t_r == ONE_Q16)
    else $error("last point issued with t below one");

  // a single-point run issues only the start point
  assert property (@(posedge clk) disable iff (!rst_n)
    issue && step_r == '0 |-> left_r == CNT_W'(1) && t_r == '0)
    else $error("zero step with more than one point left");

  // a taken curve word with points starts a run at t zero
  assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_point_count != '0 |=> !in_ready && t_r == '0)
    else $error("run did not start after curve word");

  // a stalled pipe keeps its sum stage
  assert property (@(posedge clk) disable iff (!rst_n)
    !adv && s4_valid_r |=> s4_valid_r && $stable(s4_sum_r[AXIS_X]))
    else $error("sum stage changed during stall");
`endif

endmodule

`default_nettype wire
